[rtl/lsb_stego_payload_extractor_unit_macros.svh]
// Assertion macros for the LSB stego payload extractor.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef LSB_STEGO_PAYLOAD_EXTRACTOR_UNIT_MACROS_SVH
`define LSB_STEGO_PAYLOAD_EXTRACTOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSBSPE_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSBSPE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lsbspe_pkg.sv]
// Shared constants and types for the LSB stego payload extractor.
// No dependencies; imported by every module of the block.
package lsbspe_pkg;

    // Parse phases.
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_MAGIC1 = 3'd1;
    localparam logic [2:0] PH_MAGIC2 = 3'd2;
    localparam logic [2:0] PH_EXTLEN = 3'd3;
    localparam logic [2:0] PH_EXTCHR = 3'd4;
    localparam logic [2:0] PH_PAYLEN = 3'd5;
    localparam logic [2:0] PH_PAYBYT = 3'd6;
    localparam logic [2:0] PH_IDLE   = 3'd7;

    // Result kinds.
    localparam logic [2:0] KIND_MISMATCH = 3'd0;
    localparam logic [2:0] KIND_EXT_LEN  = 3'd1;
    localparam logic [2:0] KIND_EXT_CHR  = 3'd2;
    localparam logic [2:0] KIND_PAY_LEN  = 3'd3;
    localparam logic [2:0] KIND_PAY_BYTE = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAGIC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_MAGIC_SECOND = 2'd1;
    localparam logic [1:0] CFG_HEADER_BYTES = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] MAGIC_FIRST_RST  = 8'd35;
    localparam logic [7:0] MAGIC_SECOND_RST = 8'd42;
    localparam logic [7:0] HEADER_BYTES_RST = 8'd54;

    // Bit positions that close an 8-bit and a 32-bit element.
    localparam logic [4:0] LAST_BIT_CHAR = 5'd7;
    localparam logic [4:0] LAST_BIT_LEN  = 5'd31;

    typedef struct packed {
        logic [7:0] magic_first;
        logic [7:0] magic_second;
        logic [7:0] header_bytes;
    } lsbspe_cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic        last;
    } lsbspe_res_t;

endpackage

[rtl/lsbspe_parser.sv]
// Frame parser: header skip, bit collection and element decoding for one byte.
// Depends on lsbspe_pkg and the block's assertion macro header.
`include "lsb_stego_payload_extractor_unit_macros.svh"

module lsbspe_parser
    import lsbspe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  lsbspe_cfg_t cfg,
    input  logic        step,
    input  logic        bit_in,
    input  logic        frame_start,
    output logic        res_valid,
    output lsbspe_res_t res
);

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  header_count_reg, header_count_next;
    logic [31:0] bit_shift_reg, bit_shift_next;
    logic [4:0]  bit_count_reg, bit_count_next;
    logic [31:0] element_count_reg, element_count_next;
    logic [31:0] ext_len_reg, ext_len_next;
    logic [31:0] pay_len_reg, pay_len_next;
    logic [7:0]  first_magic_reg, first_magic_next;

    // Parse logic for one word: restart, header skip, then shift one bit in.
    always_comb begin
        logic [2:0]  ph;
        logic [7:0]  hc;
        logic [31:0] sh;
        logic [4:0]  bc;
        logic [31:0] ec;
        logic [31:0] el;
        logic [31:0] pl;
        logic [7:0]  fm;
        logic [31:0] shifted;
        logic [31:0] len_word;
        logic [31:0] ec_inc;
        logic        need32;
        logic        done;

        ph = frame_start ? PH_HEADER : phase_reg;
        hc = frame_start ? 8'd0 : header_count_reg;
        sh = frame_start ? 32'd0 : bit_shift_reg;
        bc = frame_start ? 5'd0 : bit_count_reg;
        ec = frame_start ? 32'd0 : element_count_reg;
        el = frame_start ? 32'd0 : ext_len_reg;
        pl = frame_start ? 32'd0 : pay_len_reg;
        fm = frame_start ? 8'd0 : first_magic_reg;

        res_valid = 1'b0;
        res.kind  = KIND_MISMATCH;
        res.value = 32'd0;
        res.last  = 1'b0;

        phase_next         = ph;
        header_count_next  = hc;
        bit_shift_next     = sh;
        bit_count_next     = bc;
        element_count_next = ec;
        ext_len_next       = el;
        pay_len_next       = pl;
        first_magic_next   = fm;

        shifted  = 32'd0;
        len_word = 32'd0;
        ec_inc   = ec + 32'd1;
        need32   = 1'b0;
        done     = 1'b0;

        if (ph == PH_HEADER && hc < cfg.header_bytes) begin
            // Still inside the image header: count the byte and drop it.
            header_count_next = hc + 8'd1;
        end else if (ph != PH_IDLE) begin
            // Header done on this byte: its bit is the first hidden bit.
            if (ph == PH_HEADER) begin
                ph = PH_MAGIC1;
                sh = 32'd0;
                bc = 5'd0;
            end
            need32   = ph inside {PH_EXTLEN, PH_PAYLEN};
            shifted  = {sh[30:0], bit_in};
            done     = need32 ? (bc == LAST_BIT_LEN) : (bc == LAST_BIT_CHAR);
            len_word = shifted[31] ? 32'd0 : shifted;

            phase_next     = ph;
            bit_shift_next = shifted;
            bit_count_next = bc + 5'd1;

            if (done) begin
                bit_shift_next = 32'd0;
                bit_count_next = 5'd0;
                case (ph)
                    PH_MAGIC1: begin
                        first_magic_next = shifted[7:0];
                        phase_next       = PH_MAGIC2;
                    end
                    PH_MAGIC2: begin
                        if (fm != cfg.magic_first || shifted[7:0] != cfg.magic_second) begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res.kind   = KIND_MISMATCH;
                        end else begin
                            phase_next = PH_EXTLEN;
                        end
                    end
                    PH_EXTLEN: begin
                        ext_len_next       = len_word;
                        element_count_next = 32'd0;
                        phase_next         = (len_word == 32'd0) ? PH_PAYLEN : PH_EXTCHR;
                        res_valid          = 1'b1;
                        res.kind           = KIND_EXT_LEN;
                        res.value          = len_word;
                    end
                    PH_EXTCHR: begin
                        res_valid = 1'b1;
                        res.kind  = KIND_EXT_CHR;
                        res.value = {24'd0, shifted[7:0]};
                        res.last  = (ec_inc >= el);
                        if (res.last) begin
                            phase_next         = PH_PAYLEN;
                            element_count_next = 32'd0;
                        end else begin
                            element_count_next = ec_inc;
                        end
                    end
                    PH_PAYLEN: begin
                        pay_len_next       = len_word;
                        element_count_next = 32'd0;
                        phase_next         = (len_word == 32'd0) ? PH_IDLE : PH_PAYBYT;
                        res_valid          = 1'b1;
                        res.kind           = KIND_PAY_LEN;
                        res.value          = len_word;
                        res.last           = (len_word == 32'd0);
                    end
                    PH_PAYBYT: begin
                        element_count_next = ec_inc;
                        res_valid          = 1'b1;
                        res.kind           = KIND_PAY_BYTE;
                        res.value          = {24'd0, shifted[7:0]};
                        res.last           = (ec_inc >= pl);
                        if (res.last) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Parser state advances only when a word is consumed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HEADER;
            header_count_reg  <= 8'd0;
            bit_shift_reg     <= 32'd0;
            bit_count_reg     <= 5'd0;
            element_count_reg <= 32'd0;
            ext_len_reg       <= 32'd0;
            pay_len_reg       <= 32'd0;
            first_magic_reg   <= 8'd0;
        end else if (step) begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            bit_shift_reg     <= bit_shift_next;
            bit_count_reg     <= bit_count_next;
            element_count_reg <= element_count_next;
            ext_len_reg       <= ext_len_next;
            pay_len_reg       <= pay_len_next;
            first_magic_reg   <= first_magic_next;
        end
    end

    // A mismatch always parks the parser until the next frame start.
    `LSBSPE_ASSERT_NEXT(a_mismatch_idles, aclk, aresetn,
        step && res_valid && res.kind == KIND_MISMATCH, phase_reg == PH_IDLE,
        "parser did not go idle after a magic mismatch")
    // A closing result leads either to the payload length or to idle.
    `LSBSPE_ASSERT_NEXT(a_last_closes, aclk, aresetn, step && res_valid && res.last,
        phase_reg == PH_IDLE || phase_reg == PH_PAYLEN,
        "unexpected phase after a closing result")
    // No hidden bits are collected while the header is being skipped.
    `LSBSPE_ASSERT_SAME(a_header_no_bits, aclk, aresetn, phase_reg == PH_HEADER,
        bit_count_reg == 5'd0,
        "bit counter moved during header skip")

endmodule

[rtl/lsbspe_out_stage.sv]
// Result register for the master-side stream with its valid flag.
// Depends on lsbspe_pkg.
module lsbspe_out_stage
    import lsbspe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  lsbspe_res_t res,
    input  logic        m_tready,
    output logic        can_load,
    output logic        m_tvalid,
    output logic [31:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    logic        valid_reg, valid_next;
    lsbspe_res_t res_reg;

    // The register can take a new word when empty or being drained.
    assign can_load   = !valid_reg || m_tready;
    assign valid_next = can_load ? load : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds while a word waits to be taken.
    always_ff @(posedge aclk) begin
        if (can_load && load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.value;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;

endmodule

[rtl/lsb_stego_payload_extractor_unit.sv]
// Top level of the LSB stego payload extractor: ports, configuration, input register.
// Depends on lsbspe_pkg, lsbspe_parser and lsbspe_out_stage.
//
// Accepts one image byte per clock while not stalled and delivers at most one result
// word per byte, in order. A byte passes an input register, the single-pass parse
// logic and a result register, in that order. The sustained rate is one byte per
// cycle, set by the parser consuming one word from the input register each cycle
// while the result register is empty or drained. Back-pressure on the master side
// stalls the input side. No clearing pass is needed after reset. The user must write
// the configuration registers only while idle; the block itself does not enforce it.
module lsb_stego_payload_extractor_unit
    import lsbspe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    // Slave side: image bytes.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] image_byte
    input  logic        s_tuser,   // [0] frame_start
    // Master side: decoded results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] out_value
    output logic [2:0]  m_tuser,   // [2:0] out_kind
    output logic        m_tlast    // is_last
);

    lsbspe_cfg_t cfg_reg;
    logic        in_valid_reg, in_valid_next;
    logic        in_bit_reg;
    logic        in_start_reg;
    logic        can_load;
    logic        step;
    logic        res_valid;
    lsbspe_res_t res;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_first  <= MAGIC_FIRST_RST;
            cfg_reg.magic_second <= MAGIC_SECOND_RST;
            cfg_reg.header_bytes <= HEADER_BYTES_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_MAGIC_FIRST:  cfg_reg.magic_first  <= cfg_wdata;
                CFG_MAGIC_SECOND: cfg_reg.magic_second <= cfg_wdata;
                CFG_HEADER_BYTES: cfg_reg.header_bytes <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register: the parser consumes it whenever the result side can take a word.
    assign step          = in_valid_reg && can_load;
    assign s_tready      = !in_valid_reg || can_load;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Only the lowest image bit and the frame start flag are kept.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_bit_reg   <= s_tdata[0];
            in_start_reg <= s_tuser;
        end
    end

    lsbspe_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .step        (step),
        .bit_in      (in_bit_reg),
        .frame_start (in_start_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    lsbspe_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && res_valid),
        .res      (res),
        .m_tready (m_tready),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[tb/sv/lsbspe_checker.sv]
`timescale 1ns / 1ps
// Checker for the LSB stego payload extractor: watches the configuration port and both streams.
// Predicts each result word from the accepted image bytes. Depends on lsbspe_pkg.
module lsbspe_checker
    import lsbspe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] image_byte
    input  logic        s_tuser,   // [0] frame_start
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] out_value
    input  logic [2:0]  m_tuser,   // [2:0] out_kind
    input  logic        m_tlast,
    output int          fail_count,
    output int          results_due
);

    // Shadow copy of the configuration registers.
    lsbspe_cfg_t cfg;

    // Shadow parse state.
    logic [2:0]  phase;
    logic [7:0]  hdr_seen;
    logic [31:0] bit_reg;
    logic [4:0]  bit_pos;
    logic [31:0] elem_seen;
    logic [31:0] ext_total;
    logic [31:0] pay_total;
    logic [7:0]  magic_a;

    lsbspe_res_t decoded_q[$];
    int          errors = 0;

    task automatic restart_parse();
        phase = PH_HEADER;
        hdr_seen = '0;
        bit_reg = '0;
        bit_pos = '0;
        elem_seen = '0;
        ext_total = '0;
        pay_total = '0;
        magic_a = '0;
    endtask

    task automatic queue_result(input logic [2:0] kind, input logic [31:0] value,
                                input logic last);
        lsbspe_res_t r;
        r.kind = kind;
        r.value = value;
        r.last = last;
        decoded_q.push_back(r);
    endtask

    // Advance the parser by one image byte and queue the result word, if any, that it causes.
    task automatic parse_byte(input logic [7:0] img, input logic start);
        logic [31:0] val;
        logic        is_len;
        logic        last;
        if (start) restart_parse();
        if (phase == PH_IDLE) return;
        if (phase == PH_HEADER) begin
            if (hdr_seen < cfg.header_bytes) begin
                hdr_seen = hdr_seen + 8'd1;
                return;
            end
            phase = PH_MAGIC1;
            bit_reg = '0;
            bit_pos = '0;
        end
        is_len = (phase == PH_EXTLEN) || (phase == PH_PAYLEN);
        bit_reg = {bit_reg[30:0], img[0]};
        if (bit_pos != (is_len ? LAST_BIT_LEN : LAST_BIT_CHAR)) begin
            bit_pos = bit_pos + 5'd1;
            return;
        end
        val = is_len ? bit_reg : {24'd0, bit_reg[7:0]};
        bit_reg = '0;
        bit_pos = '0;
        case (phase)
            PH_MAGIC1: begin
                magic_a = val[7:0];
                phase = PH_MAGIC2;
            end
            PH_MAGIC2: begin
                if (magic_a != cfg.magic_first || val[7:0] != cfg.magic_second) begin
                    phase = PH_IDLE;
                    queue_result(KIND_MISMATCH, 32'd0, 1'b0);
                end else begin
                    phase = PH_EXTLEN;
                end
            end
            PH_EXTLEN: begin
                // A length with the sign bit set counts as zero.
                if (val[31]) val = '0;
                ext_total = val;
                elem_seen = '0;
                phase = (val == 0) ? PH_PAYLEN : PH_EXTCHR;
                queue_result(KIND_EXT_LEN, val, 1'b0);
            end
            PH_EXTCHR: begin
                elem_seen = elem_seen + 32'd1;
                last = (elem_seen >= ext_total);
                if (last) begin
                    phase = PH_PAYLEN;
                    elem_seen = '0;
                end
                queue_result(KIND_EXT_CHR, val, last);
            end
            PH_PAYLEN: begin
                if (val[31]) val = '0;
                pay_total = val;
                elem_seen = '0;
                last = (val == 0);
                phase = last ? PH_IDLE : PH_PAYBYT;
                queue_result(KIND_PAY_LEN, val, last);
            end
            PH_PAYBYT: begin
                elem_seen = elem_seen + 32'd1;
                last = (elem_seen >= pay_total);
                if (last) phase = PH_IDLE;
                queue_result(KIND_PAY_BYTE, val, last);
            end
            default: phase = PH_IDLE;
        endcase
    endtask

    // Compare one delivered result word with the oldest prediction.
    task automatic check_result();
        lsbspe_res_t want;
        if (decoded_q.size() == 0) begin
            $error("result word with nothing pending: kind %0d value %0h last %0b",
                   m_tuser, m_tdata, m_tlast);
            errors++;
            return;
        end
        want = decoded_q.pop_front();
        if (m_tuser !== want.kind) begin
            $error("out_kind: expected %0d, actual %0d", want.kind, m_tuser);
            errors++;
        end
        if (m_tdata !== want.value) begin
            $error("out_value: expected %0h, actual %0h", want.value, m_tdata);
            errors++;
        end
        if (m_tlast !== want.last) begin
            $error("is_last: expected %0b, actual %0b", want.last, m_tlast);
            errors++;
        end
    endtask

    // Results are checked before the byte of the same edge is parsed; a byte's own
    // result can never leave in the cycle it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg.magic_first = MAGIC_FIRST_RST;
            cfg.magic_second = MAGIC_SECOND_RST;
            cfg.header_bytes = HEADER_BYTES_RST;
            restart_parse();
            decoded_q.delete();
        end else begin
            if (m_tvalid === 1'b1 && m_tready === 1'b1) check_result();
            if (cfg_wr_en === 1'b1) begin
                case (cfg_addr)
                    CFG_MAGIC_FIRST:  cfg.magic_first = cfg_wdata;
                    CFG_MAGIC_SECOND: cfg.magic_second = cfg_wdata;
                    CFG_HEADER_BYTES: cfg.header_bytes = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid === 1'b1 && s_tready === 1'b1) parse_byte(s_tdata, s_tuser);
        end
        fail_count <= errors;
        results_due <= decoded_q.size();
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Top of the LSB stego payload extractor testbench: clock, reset, stimulus and verdict.
// Depends on lsbspe_pkg, lsb_stego_payload_extractor_unit and lsbspe_checker.
module tb_top;
    import lsbspe_pkg::*;

    typedef struct packed {
        logic       start;
        logic [7:0] data;
    } img_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = CFG_MAGIC_FIRST;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int results_due;

    // Stimulus controls.
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        rx_hold = 0;
    img_word_t image_q[$];
    bit        frame_open = 1'b0;
    logic [7:0] cur_m1 = MAGIC_FIRST_RST;
    logic [7:0] cur_m2 = MAGIC_SECOND_RST;
    logic [7:0] cur_hdr = HEADER_BYTES_RST;

    lsb_stego_payload_extractor_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    lsbspe_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off while rx_hold counts down.
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold <= rx_hold - 1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

    // One image byte carrying a hidden bit in its LSB; upper bits are random.
    task automatic put_bit(input logic b);
        img_word_t   w;
        logic [31:0] r;
        r = $urandom;
        w.start = frame_open;
        w.data = {r[7:1], b};
        frame_open = 1'b0;
        image_q.push_back(w);
    endtask

    task automatic put_field(input logic [31:0] v, input int width);
        for (int i = width - 1; i >= 0; i--) put_bit(v[i]);
    endtask

    // Header bytes, hidden magic, both lengths and the given number of characters.
    task automatic make_frame(input bit start, input int hdr, input logic [7:0] m1,
                              input logic [7:0] m2, input logic [31:0] ext_len,
                              input int n_ext, input logic [31:0] pay_len, input int n_pay);
        frame_open = start;
        repeat (hdr) put_bit(1'($urandom_range(0, 1)));
        put_field({24'd0, m1}, 8);
        put_field({24'd0, m2}, 8);
        put_field(ext_len, 32);
        repeat (n_ext) put_field($urandom, 8);
        put_field(pay_len, 32);
        repeat (n_pay) put_field($urandom, 8);
    endtask

    // Bytes with random data and an occasional frame start.
    task automatic put_noise(input int n);
        img_word_t w;
        repeat (n) begin
            w.start = ($urandom_range(0, 15) == 0);
            w.data = 8'($urandom);
            image_q.push_back(w);
        end
    endtask

    // Offer one word, wait for its handshake, then idle at random.
    task automatic push_word(input img_word_t w);
        s_tdata <= w.data;
        s_tuser <= w.start;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic send_queued();
        while (image_q.size() != 0) push_word(image_q.pop_front());
    endtask

    // Stop sending until every predicted result word has left the block.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all three registers while the block is idle.
    task automatic load_config(input logic [7:0] m1, input logic [7:0] m2,
                               input logic [7:0] hdr);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_addr <= CFG_MAGIC_FIRST;
        cfg_wdata <= m1;
        @(posedge aclk);
        cfg_addr <= CFG_MAGIC_SECOND;
        cfg_wdata <= m2;
        @(posedge aclk);
        cfg_addr <= CFG_HEADER_BYTES;
        cfg_wdata <= hdr;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_m1 = m1;
        cur_m2 = m2;
        cur_hdr = hdr;
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // One random frame: mostly well formed, some cut short, misaligned, bad magic or pure noise.
    task automatic random_frame(input int pay_max);
        int          pick;
        int          n_ext;
        int          n_pay;
        int          hdr;
        int          cut;
        logic [31:0] ext_len;
        logic [31:0] pay_len;
        logic [7:0]  m1;
        logic [7:0]  m2;
        pick = $urandom_range(0, 99);
        n_ext = $urandom_range(0, 4);
        n_pay = $urandom_range(0, pay_max);
        ext_len = n_ext;
        pay_len = n_pay;
        hdr = int'(cur_hdr);
        m1 = cur_m1;
        m2 = cur_m2;
        // Occasionally a negative length, which reads as zero.
        if ($urandom_range(0, 19) == 0) begin
            ext_len = $urandom;
            ext_len[31] = 1'b1;
            n_ext = 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            pay_len = $urandom;
            pay_len[31] = 1'b1;
            n_pay = 0;
        end
        if (pick >= 88) begin
            put_noise($urandom_range(8, 40));
            return;
        end
        if (pick >= 78) begin
            if ($urandom_range(0, 1)) m1 = m1 ^ (8'd1 << $urandom_range(0, 7));
            else m2 = m2 ^ (8'd1 << $urandom_range(0, 7));
        end else if (pick >= 74 && hdr < 255) begin
            hdr = hdr + 1;
        end
        make_frame(1'b1, hdr, m1, m2, ext_len, n_ext, pay_len, n_pay);
        if (pick >= 64 && pick < 74) begin
            cut = $urandom_range(1, image_q.size() - 1);
            repeat (cut) void'(image_q.pop_back());
        end
    endtask

    initial begin
        int rand_items;
        int frame_no;

        // Reset once, then release it.
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Parsing begins after reset with no frame start at all.
        // The receiver holds off long enough for the block to fill and stall its input.
        set_idle(23, 23);
        rx_hold <= 300;
        make_frame(1'b0, int'(HEADER_BYTES_RST), MAGIC_FIRST_RST, MAGIC_SECOND_RST,
                   32'd1, 1, 32'd2, 2);
        send_queued();

        // Extreme register values, no header, sender idling.
        load_config(8'h00, 8'hFF, 8'h00);
        set_idle(59, 0);
        // Negative extension length and all-ones payload length both read as zero;
        // the zero payload length ends the frame and trailing bytes are ignored.
        make_frame(1'b1, 0, 8'h00, 8'hFF, 32'h8000_0000, 0, 32'hFFFF_FFFF, 0);
        frame_open = 1'b0;
        repeat (12) put_bit(1'($urandom_range(0, 1)));
        // Mismatch on the first and on the second magic character, then ignored bytes.
        frame_open = 1'b1;
        put_field(32'h01, 8);
        put_field(32'hFF, 8);
        repeat (8) put_bit(1'($urandom_range(0, 1)));
        frame_open = 1'b1;
        put_field(32'h00, 8);
        put_field(32'hFE, 8);
        repeat (8) put_bit(1'($urandom_range(0, 1)));
        // Huge extension length cut short by a new frame start.
        make_frame(1'b1, 0, 8'h00, 8'hFF, 32'h7FFF_FFFF, 2, 32'd0, 0);
        // Extremes of character and byte values.
        frame_open = 1'b1;
        put_field(8'h00, 8);
        put_field(8'hFF, 8);
        put_field(32'd2, 32);
        put_field(8'h00, 8);
        put_field(8'hFF, 8);
        put_field(32'd3, 32);
        put_field(8'hFF, 8);
        put_field(8'h00, 8);
        put_field(8'hA5, 8);
        send_queued();

        // Largest header, restarted early in the header by a new frame; receiver stalling.
        load_config(8'hFF, 8'h00, 8'hFF);
        set_idle(0, 59);
        frame_open = 1'b1;
        repeat (8) put_bit(1'($urandom_range(0, 1)));
        make_frame(1'b1, 255, 8'hFF, 8'h00, 32'd0, 0, 32'd1, 1);
        send_queued();

        // Random part, cycling through the idling phases frame by frame.
        load_config(8'($urandom), 8'($urandom), 8'($urandom_range(0, 12)));
        rand_items = 0;
        frame_no = 0;
        while (rand_items < 200) begin
            case (frame_no % 4)
                0: set_idle(0, 0);
                1: set_idle(59, 0);
                2: set_idle(0, 59);
                default: set_idle(23, 23);
            endcase
            if (frame_no % 5 == 4) begin
                load_config(8'($urandom), 8'($urandom),
                            8'(($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 12)));
            end
            random_frame(8);
            rand_items += image_q.size();
            if ($urandom_range(0, 3) == 0) put_noise($urandom_range(1, 6));
            send_queued();
            frame_no++;
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
